// File: hdl/resf_pkg.sv
// shared types, constants and helper functions of the rod edge stretch force unit
package resf_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned N_PAIRS     = 6;
  localparam int unsigned N_LANES     = 9;
  localparam int unsigned W_STEPS     = 17;
  localparam int unsigned RECIP_STEPS = 33;
  localparam int unsigned RATIO_STEPS = 47;
  localparam int unsigned DIV_STEPS   = W_STEPS + RECIP_STEPS;

  localparam int unsigned LN_RATIO    = 0;
  localparam int unsigned LN_RCP_REST = 1;
  localparam int unsigned LN_RCP_LEN  = 2;
  localparam int unsigned LN_PAIR0    = 3;

  // pair order xx, xy, xz, yy, yz, zz
  localparam logic [1:0] PAIR_I [N_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_J [N_PAIRS] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
  localparam logic [N_PAIRS-1:0] PAIR_DIAG = 6'b101001;

  localparam logic [48:0] ONE_Q = 49'(1) << FRAC_BITS;

  typedef struct packed {
    logic [3:0]          limb_sel;
    logic [9:0]          edge_idx;
    logic [30:0]         stiff;
    logic [2:0][17:0]    tan;
    logic [N_PAIRS-1:0]  pneg;
    logic [30:0]         len;
    logic [30:0]         rest;
    logic [63:0]         norm_sq;
    logic                err;
  } meta_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [79:0] num;
    logic [47:0] quo;
  } lane_t;

  typedef struct packed {
    meta_t                    meta;
    lane_t [N_LANES-1:0]      lane;
  } div_t;

  typedef struct packed {
    logic [3:0]              limb_sel;
    logic [9:0]              edge_idx;
    logic [2:0][31:0]        frc;
    logic [N_PAIRS-1:0][31:0] blk;
    logic                    err;
  } res_t;

  // one restoring long division step, one quotient bit
  function automatic lane_t lane_step(lane_t ln, logic [63:0] den);
    logic [64:0] t;
    lane_t r;
    r = ln;
    t = {ln.rem, ln.num[79]};
    r.num = {ln.num[78:0], 1'b0};
    if (t >= {1'b0, den}) begin
      r.rem = 64'(t - {1'b0, den});
      r.quo = {ln.quo[46:0], 1'b1};
    end else begin
      r.rem = t[63:0];
      r.quo = {ln.quo[46:0], 1'b0};
    end
    return r;
  endfunction

  // turn a finished weight quotient into the dividend (w << frac) / len
  function automatic lane_t lane_reload(lane_t ln);
    lane_t r;
    r.rem = '0;
    r.num = {ln.quo[W_STEPS-1:0], 16'd0, 47'd0};
    r.quo = '0;
    return r;
  endfunction

  // saturate a signed magnitude to the int32 range
  function automatic logic [31:0] sat32(logic [64:0] m, logic neg);
    logic [31:0] r;
    if (!neg) begin
      r = (m > 65'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end else begin
      r = (m > 65'h0_8000_0000) ? 32'h8000_0000 : 32'(~m[31:0] + 32'd1);
    end
    return r;
  endfunction

endpackage

// File: hdl/resf_prep.sv
// front stages: component products, squared norm and divider lane setup
module resf_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [3:0]           limb_index_i,
  input  logic [9:0]           edge_index_i,
  input  logic [30:0]          axial_stiffness_i,
  input  logic signed [31:0]   delta_x_i,
  input  logic signed [31:0]   delta_y_i,
  input  logic signed [31:0]   delta_z_i,
  input  logic [30:0]          edge_length_i,
  input  logic [30:0]          rest_length_i,
  input  logic signed [17:0]   tangent_x_i,
  input  logic signed [17:0]   tangent_y_i,
  input  logic signed [17:0]   tangent_z_i,
  output logic                 valid_o,
  output resf_pkg::div_t       stage_o
);

  logic [2:0][31:0] dm;
  logic [2:0]       dn;
  resf_pkg::meta_t  a_meta_d, a_meta_q;
  logic [resf_pkg::N_PAIRS-1:0][63:0] a_prod_d, a_prod_q;
  logic             a_vld_q;
  resf_pkg::div_t   b_d, b_q;
  logic             b_vld_q;
  logic [63:0]      nsq;

  always_comb begin
    dn = {delta_z_i[31], delta_y_i[31], delta_x_i[31]};
    dm[0] = delta_x_i[31] ? 32'(~delta_x_i + 32'sd1) : delta_x_i;
    dm[1] = delta_y_i[31] ? 32'(~delta_y_i + 32'sd1) : delta_y_i;
    dm[2] = delta_z_i[31] ? 32'(~delta_z_i + 32'sd1) : delta_z_i;
    a_meta_d          = '0;
    a_meta_d.limb_sel = limb_index_i;
    a_meta_d.edge_idx = edge_index_i;
    a_meta_d.stiff    = axial_stiffness_i;
    a_meta_d.tan      = {tangent_z_i, tangent_y_i, tangent_x_i};
    a_meta_d.len      = edge_length_i;
    a_meta_d.rest     = rest_length_i;
    for (int p = 0; p < resf_pkg::N_PAIRS; p++) begin
      a_prod_d[p]      = 64'(dm[resf_pkg::PAIR_I[p]]) * 64'(dm[resf_pkg::PAIR_J[p]]);
      a_meta_d.pneg[p] = dn[resf_pkg::PAIR_I[p]] ^ dn[resf_pkg::PAIR_J[p]];
    end
  end

  always_comb begin
    nsq = a_prod_q[0] + a_prod_q[3] + a_prod_q[5];
    b_d = '0;
    b_d.meta         = a_meta_q;
    b_d.meta.norm_sq = nsq;
    b_d.meta.err     = (a_meta_q.len == '0) || (a_meta_q.rest == '0) || (nsq == '0);
    // (len << frac) / rest, 47 quotient bits
    b_d.lane[resf_pkg::LN_RATIO].num    = {a_meta_q.len, 16'd0, 33'd0};
    // 2^(2 frac) / rest and / len, 33 quotient bits
    b_d.lane[resf_pkg::LN_RCP_REST].num = {1'b1, 79'd0};
    b_d.lane[resf_pkg::LN_RCP_LEN].num  = {1'b1, 79'd0};
    // (p << frac) / norm_sq, 17 quotient bits, top of dividend preloads the remainder
    for (int p = 0; p < resf_pkg::N_PAIRS; p++) begin
      b_d.lane[resf_pkg::LN_PAIR0+p].rem = {1'b0, a_prod_q[p][63:1]};
      b_d.lane[resf_pkg::LN_PAIR0+p].num = {a_prod_q[p][0], 16'd0, 63'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_meta_q <= a_meta_d;
      a_prod_q <= a_prod_d;
      b_q      <= b_d;
    end
  end

  assign valid_o = b_vld_q;
  assign stage_o = b_q;

endmodule

// File: hdl/resf_divide.sv
// pipelined long division array, at most one quotient bit per stage and lane
module resf_divide (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  resf_pkg::div_t  stage_i,
  output logic            valid_o,
  output resf_pkg::div_t  stage_o
);

  resf_pkg::div_t cur [resf_pkg::DIV_STEPS];
  resf_pkg::div_t nx  [resf_pkg::DIV_STEPS];
  resf_pkg::div_t st_q [resf_pkg::DIV_STEPS];
  logic [resf_pkg::DIV_STEPS-1:0] vld_q;

  for (genvar k = 0; k < resf_pkg::DIV_STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign cur[k] = stage_i;
    end else begin : g_rest
      assign cur[k] = st_q[k-1];
    end

    always_comb begin
      nx[k] = cur[k];
      if (k < resf_pkg::RATIO_STEPS) begin
        nx[k].lane[resf_pkg::LN_RATIO] =
          resf_pkg::lane_step(cur[k].lane[resf_pkg::LN_RATIO], {33'd0, cur[k].meta.rest});
      end
      if (k < resf_pkg::RECIP_STEPS) begin
        nx[k].lane[resf_pkg::LN_RCP_REST] =
          resf_pkg::lane_step(cur[k].lane[resf_pkg::LN_RCP_REST], {33'd0, cur[k].meta.rest});
        nx[k].lane[resf_pkg::LN_RCP_LEN] =
          resf_pkg::lane_step(cur[k].lane[resf_pkg::LN_RCP_LEN], {33'd0, cur[k].meta.len});
      end
      for (int p = 0; p < resf_pkg::N_PAIRS; p++) begin
        if (k < resf_pkg::W_STEPS) begin
          nx[k].lane[resf_pkg::LN_PAIR0+p] =
            resf_pkg::lane_step(cur[k].lane[resf_pkg::LN_PAIR0+p], cur[k].meta.norm_sq);
        end else if (k == resf_pkg::W_STEPS) begin
          // weight done: divide it by the current length
          nx[k].lane[resf_pkg::LN_PAIR0+p] = resf_pkg::lane_step(
            resf_pkg::lane_reload(cur[k].lane[resf_pkg::LN_PAIR0+p]),
            {33'd0, cur[k].meta.len});
        end else begin
          nx[k].lane[resf_pkg::LN_PAIR0+p] =
            resf_pkg::lane_step(cur[k].lane[resf_pkg::LN_PAIR0+p], {33'd0, cur[k].meta.len});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[resf_pkg::DIV_STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < resf_pkg::DIV_STEPS; k++) begin
        st_q[k] <= nx[k];
      end
    end
  end

  assign valid_o = vld_q[resf_pkg::DIV_STEPS-1];
  assign stage_o = st_q[resf_pkg::DIV_STEPS-1];

  // ratio remainder stays below the rest length
  a_ratio_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stage_o.meta.err) |->
      (stage_o.lane[resf_pkg::LN_RATIO].rem < {33'd0, stage_o.meta.rest}))
    else $error("ratio remainder not below divisor");

  // a finished reciprocal of the length never exceeds 2^32
  a_rcp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stage_o.meta.err) |->
      (stage_o.lane[resf_pkg::LN_RCP_LEN].quo[47:33] == '0))
    else $error("length reciprocal out of range");

endmodule

// File: hdl/resf_post.sv
// back stages: strain, coefficient sums, stiffness products and saturation
module resf_post (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  resf_pkg::div_t  stage_i,
  output logic            valid_o,
  output resf_pkg::res_t  res_o
);

  typedef struct packed {
    logic [3:0]                         limb_sel;
    logic [9:0]                         edge_idx;
    logic [30:0]                        stiff;
    logic                               err;
    logic [2:0][32:0]                   q1m;
    logic [2:0]                         q1n;
    logic [47:0]                        em;
    logic                               en;
    logic [resf_pkg::N_PAIRS-1:0][33:0] vm;
    logic [resf_pkg::N_PAIRS-1:0]       vn;
  } post1_t;

  typedef struct packed {
    logic [3:0]                         limb_sel;
    logic [9:0]                         edge_idx;
    logic                               err;
    logic [2:0][56:0]                   flo;
    logic [2:0][56:0]                   fhi;
    logic [2:0]                         fn;
    logic [resf_pkg::N_PAIRS-1:0][64:0] bp;
    logic [resf_pkg::N_PAIRS-1:0]       bn;
  } post2_t;

  post1_t         p1_d, p1_q;
  post2_t         p2_d, p2_q;
  resf_pkg::res_t p3_d, p3_q;
  logic [2:0]     vld_q;

  logic signed [48:0] eps;
  logic signed [34:0] cc;
  logic signed [35:0] sv;
  logic signed [17:0] tv;
  logic [17:0]        tm;
  logic [48:0]        tp;
  logic [80:0]        fs;

  // stage 1: strain, diagonal shift, signed block coefficients, stiffness times tangent
  always_comb begin
    p1_d          = '0;
    p1_d.limb_sel = stage_i.meta.limb_sel;
    p1_d.edge_idx = stage_i.meta.edge_idx;
    p1_d.stiff    = stage_i.meta.stiff;
    p1_d.err      = stage_i.meta.err;
    eps     = $signed({2'b00, stage_i.lane[resf_pkg::LN_RATIO].quo[46:0]})
              - $signed(resf_pkg::ONE_Q);
    p1_d.en = eps[48];
    p1_d.em = eps[48] ? 48'(-eps) : eps[47:0];
    cc = $signed({2'b00, stage_i.lane[resf_pkg::LN_RCP_REST].quo[32:0]})
         - $signed({2'b00, stage_i.lane[resf_pkg::LN_RCP_LEN].quo[32:0]});
    tv = '0;
    tm = '0;
    tp = '0;
    sv = '0;
    for (int k = 0; k < 3; k++) begin
      tv = $signed(stage_i.meta.tan[k]);
      tm = tv[17] ? 18'(-tv) : tv;
      tp = 49'(stage_i.meta.stiff) * 49'(tm);
      p1_d.q1m[k] = tp[48:16];
      p1_d.q1n[k] = tv[17];
    end
    for (int p = 0; p < resf_pkg::N_PAIRS; p++) begin
      sv = $signed({3'b000, stage_i.lane[resf_pkg::LN_PAIR0+p].quo[32:0]});
      if (stage_i.meta.pneg[p]) begin
        sv = -sv;
      end
      if (resf_pkg::PAIR_DIAG[p]) begin
        sv = sv + 36'(cc);
      end
      p1_d.vn[p] = sv[35];
      p1_d.vm[p] = sv[35] ? 34'(-sv) : sv[33:0];
    end
  end

  // stage 2: multipliers, the long strain operand in two halves
  always_comb begin
    p2_d.limb_sel = p1_q.limb_sel;
    p2_d.edge_idx = p1_q.edge_idx;
    p2_d.err      = p1_q.err;
    for (int k = 0; k < 3; k++) begin
      p2_d.flo[k] = 57'(p1_q.q1m[k]) * 57'(p1_q.em[23:0]);
      p2_d.fhi[k] = 57'(p1_q.q1m[k]) * 57'(p1_q.em[47:24]);
      p2_d.fn[k]  = p1_q.q1n[k] ^ p1_q.en;
    end
    for (int p = 0; p < resf_pkg::N_PAIRS; p++) begin
      p2_d.bp[p] = 65'(p1_q.stiff) * 65'(p1_q.vm[p]);
      p2_d.bn[p] = p1_q.vn[p];
    end
  end

  // stage 3: recombine, drop fraction bits, saturate, zero on error
  always_comb begin
    p3_d.limb_sel = p2_q.limb_sel;
    p3_d.edge_idx = p2_q.edge_idx;
    p3_d.err      = p2_q.err;
    fs = '0;
    for (int k = 0; k < 3; k++) begin
      fs = {p2_q.fhi[k], 24'd0} + 81'(p2_q.flo[k]);
      p3_d.frc[k] = p2_q.err ? 32'd0
                    : resf_pkg::sat32(fs[80:resf_pkg::FRAC_BITS], p2_q.fn[k]);
    end
    for (int p = 0; p < resf_pkg::N_PAIRS; p++) begin
      p3_d.blk[p] = p2_q.err ? 32'd0
                    : resf_pkg::sat32(65'(p2_q.bp[p][64:resf_pkg::FRAC_BITS]), p2_q.bn[p]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
    end
  end

  assign valid_o = vld_q[2];
  assign res_o   = p3_q;

  // a length error zeroes every force and block entry
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.err) |-> (res_o.frc == '0 && res_o.blk == '0))
    else $error("error beat carries nonzero data");

endmodule

// File: hdl/rod_edge_stretch_force_unit.sv
// top level of the rod edge stretch force unit
//
// usage:
//  - input channel in_valid_i / in_ready_o carries one rod edge per beat:
//    indices, stiffness, node difference, lengths and unit tangent (signed Q2.16)
//  - output channel out_valid_o / out_ready_i carries one result beat per
//    input beat, in order: indices, force vector, six unique entries of the
//    symmetric stiffness block, and a length error flag
//  - the pipeline has 2 front stages (products, norm), 50 long division
//    stages (17 for the pair weights, 33 more for the divide by the length)
//    and 3 back stages
//  - throughput is one beat per cycle unless the receiver stalls; a new edge
//    enters each cycle, each divider stage retiring at most one bit per lane
//  - the last back stage is the output register; when the receiver stalls
//    the whole pipeline holds and in_ready_o drops, nothing is lost
//  - reset clears every valid bit; payload registers are not reset
//  - a zero current length, rest length or difference norm gives a beat
//    with the length error set and all force and block fields zero
module rod_edge_stretch_force_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [3:0]          limb_index_i,
  input  logic [9:0]          edge_index_i,
  input  logic [30:0]         axial_stiffness_i,
  input  logic signed [31:0]  delta_x_i,
  input  logic signed [31:0]  delta_y_i,
  input  logic signed [31:0]  delta_z_i,
  input  logic [30:0]         edge_length_i,
  input  logic [30:0]         rest_length_i,
  input  logic signed [17:0]  tangent_x_i,
  input  logic signed [17:0]  tangent_y_i,
  input  logic signed [17:0]  tangent_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          limb_out_o,
  output logic [9:0]          edge_out_o,
  output logic signed [31:0]  force_x_o,
  output logic signed [31:0]  force_y_o,
  output logic signed [31:0]  force_z_o,
  output logic signed [31:0]  block_xx_o,
  output logic signed [31:0]  block_xy_o,
  output logic signed [31:0]  block_xz_o,
  output logic signed [31:0]  block_yy_o,
  output logic signed [31:0]  block_yz_o,
  output logic signed [31:0]  block_zz_o,
  output logic                length_error_o
);

  // global advance: the pipeline moves unless a finished beat waits
  logic           adv;
  logic           prep_vld;
  resf_pkg::div_t prep_st;
  logic           div_vld;
  resf_pkg::div_t div_st;
  logic           res_vld;
  resf_pkg::res_t res;

  assign adv        = !res_vld || out_ready_i;
  assign in_ready_o = adv;

  resf_prep u_prep (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .valid_i           (in_valid_i),
    .limb_index_i      (limb_index_i),
    .edge_index_i      (edge_index_i),
    .axial_stiffness_i (axial_stiffness_i),
    .delta_x_i         (delta_x_i),
    .delta_y_i         (delta_y_i),
    .delta_z_i         (delta_z_i),
    .edge_length_i     (edge_length_i),
    .rest_length_i     (rest_length_i),
    .tangent_x_i       (tangent_x_i),
    .tangent_y_i       (tangent_y_i),
    .tangent_z_i       (tangent_z_i),
    .valid_o           (prep_vld),
    .stage_o           (prep_st)
  );

  // long divisions: strain ratio, both reciprocals, pair weights then / length
  resf_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (prep_vld),
    .stage_i (prep_st),
    .valid_o (div_vld),
    .stage_o (div_st)
  );

  resf_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (div_vld),
    .stage_i (div_st),
    .valid_o (res_vld),
    .res_o   (res)
  );

  assign out_valid_o    = res_vld;
  assign limb_out_o     = res.limb_sel;
  assign edge_out_o     = res.edge_idx;
  assign force_x_o      = res.frc[0];
  assign force_y_o      = res.frc[1];
  assign force_z_o      = res.frc[2];
  assign block_xx_o     = res.blk[0];
  assign block_xy_o     = res.blk[1];
  assign block_xz_o     = res.blk[2];
  assign block_yy_o     = res.blk[3];
  assign block_yz_o     = res.blk[4];
  assign block_zz_o     = res.blk[5];
  assign length_error_o = res.err;

  // a stall freezes the interior of the pipeline
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(div_vld) && $stable(prep_vld)))
    else $error("pipeline moved during a stall");

endmodule
